// ----- rtl/gpr_pkg.sv -----
// shared types and constants of the glyph to pixel renderer
package gpr_pkg;

    // font store geometry
    localparam int GPR_STORE_DEPTH = 2048;
    localparam int GPR_STORE_AW    = 11;

    // font size limits
    localparam logic [3:0] GPR_MAX_FONT_WIDTH  = 4'd8;
    localparam logic [3:0] GPR_MAX_FONT_HEIGHT = 4'd8;

    // leftmost glyph bit of a font byte
    localparam logic [7:0] GPR_LEFT_BIT = 8'h80;

    // stream widths
    localparam int GPR_S_TDATA_W = 112;
    localparam int GPR_M_TDATA_W = 64;

    // configuration port
    localparam int GPR_CFG_IDX_W  = 3;
    localparam int GPR_CFG_DATA_W = 32;

    localparam logic [GPR_CFG_IDX_W-1:0] GPR_CFG_FRAME_BASE  = 3'd0;
    localparam logic [GPR_CFG_IDX_W-1:0] GPR_CFG_LINE_PITCH  = 3'd1;
    localparam logic [GPR_CFG_IDX_W-1:0] GPR_CFG_BYTES_PIXEL = 3'd2;
    localparam logic [GPR_CFG_IDX_W-1:0] GPR_CFG_FONT_WIDTH  = 3'd3;
    localparam logic [GPR_CFG_IDX_W-1:0] GPR_CFG_FONT_HEIGHT = 3'd4;

    // input item kinds carried on s_tuser
    localparam logic GPR_KIND_LOAD = 1'b0;
    localparam logic GPR_KIND_DRAW = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_write;   // write the font byte of the current transaction
        logic latch_draw;   // capture the draw transaction
        logic calc_prod;    // cell scaling products
        logic calc_scaled;  // pitch and pixel size products
        logic calc_origin;  // cell origin address, reset pixel counters
        logic fetch_row;    // read one glyph row from the font store
        logic emit_pixel;   // load one pixel into the output register
    } gpr_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic draw_item;    // offered transaction is a draw
        logic size_zero;    // font width or height is zero
        logic out_free;     // output register can take a pixel
        logic row_end;      // current pixel is the last of its row
        logic cell_end;     // current pixel is the last of the cell
    } gpr_status_t;

    // saturate a font size to its maximum
    function automatic logic [3:0] gpr_clamp_size(input logic [3:0] v,
                                                  input logic [3:0] maxv);
        return (v > maxv) ? maxv : v;
    endfunction

endpackage

// ----- rtl/gpr_ctrl.sv -----
// controller state machine of the glyph to pixel renderer
module gpr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  gpr_pkg::gpr_status_t status,
    output gpr_pkg::gpr_cmd_t    cmd
);
    import gpr_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PROD   = 3'd1;
    localparam logic [2:0] ST_SCALE  = 3'd2;
    localparam logic [2:0] ST_ORIGIN = 3'd3;
    localparam logic [2:0] ST_FETCH  = 3'd4;
    localparam logic [2:0] ST_PIXEL  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (!status.draw_item) begin
                        cmd.load_write = 1'b1;
                    end else if (!status.size_zero) begin
                        cmd.latch_draw = 1'b1;
                        state_next     = ST_PROD;
                    end
                end
            end
            ST_PROD: begin
                cmd.calc_prod = 1'b1;
                state_next    = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.calc_scaled = 1'b1;
                state_next      = ST_ORIGIN;
            end
            ST_ORIGIN: begin
                cmd.calc_origin = 1'b1;
                state_next      = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fetch_row = 1'b1;
                state_next    = ST_PIXEL;
            end
            ST_PIXEL: begin
                if (status.out_free) begin
                    cmd.emit_pixel = 1'b1;
                    if (status.cell_end) begin
                        state_next = ST_IDLE;
                    end else if (status.row_end) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/gpr_datapath.sv -----
// datapath of the glyph to pixel renderer: config, font store, address math, output
module gpr_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [gpr_pkg::GPR_CFG_IDX_W-1:0]     cfg_index,
    input  logic [gpr_pkg::GPR_CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [gpr_pkg::GPR_S_TDATA_W-1:0]     s_tdata,
    input  logic                                  s_tuser,
    input  gpr_pkg::gpr_cmd_t                     cmd,
    output gpr_pkg::gpr_status_t                  status,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [gpr_pkg::GPR_M_TDATA_W-1:0]     m_tdata,
    output logic                                  m_tlast
);
    import gpr_pkg::*;

    // input fields
    logic [7:0]              in_col;
    logic [7:0]              in_row;
    logic [7:0]              in_code;
    logic [31:0]             in_fg;
    logic [31:0]             in_bg;
    logic [GPR_STORE_AW-1:0] in_faddr;
    logic [7:0]              in_fbyte;

    assign in_col   = s_tdata[7:0];
    assign in_row   = s_tdata[15:8];
    assign in_code  = s_tdata[23:16];
    assign in_fg    = s_tdata[55:24];
    assign in_bg    = s_tdata[87:56];
    assign in_faddr = s_tdata[98:88];
    assign in_fbyte = s_tdata[106:99];

    // configuration registers
    logic [31:0] frame_base_reg;
    logic [15:0] line_pitch_reg;
    logic [2:0]  bpp_reg;
    logic [3:0]  font_width_reg;
    logic [3:0]  font_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg  <= 32'd0;
            line_pitch_reg  <= 16'd4096;
            bpp_reg         <= 3'd4;
            font_width_reg  <= 4'd8;
            font_height_reg <= 4'd8;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                GPR_CFG_FRAME_BASE:  frame_base_reg  <= cfg_wdata;
                GPR_CFG_LINE_PITCH:  line_pitch_reg  <= cfg_wdata[15:0];
                GPR_CFG_BYTES_PIXEL: bpp_reg         <= cfg_wdata[2:0];
                GPR_CFG_FONT_WIDTH:  font_width_reg  <= cfg_wdata[3:0];
                GPR_CFG_FONT_HEIGHT: font_height_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // saturated font size
    logic [3:0] fw;
    logic [3:0] fh;
    assign fw = gpr_clamp_size(font_width_reg, GPR_MAX_FONT_WIDTH);
    assign fh = gpr_clamp_size(font_height_reg, GPR_MAX_FONT_HEIGHT);

    // captured draw transaction
    logic [7:0]  col_reg;
    logic [7:0]  row_reg;
    logic [7:0]  code_reg;
    logic [31:0] fg_reg;
    logic [31:0] bg_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_draw) begin
            col_reg  <= in_col;
            row_reg  <= in_row;
            code_reg <= in_code;
            fg_reg   <= in_fg;
            bg_reg   <= in_bg;
        end
    end

    // origin arithmetic: cell scaling products, then pitch and pixel size products
    logic [11:0]             row_fh_reg;
    logic [11:0]             col_fw_reg;
    logic [GPR_STORE_AW-1:0] gbase_reg;
    logic [27:0]             row_term_reg;
    logic [14:0]             col_term_reg;
    logic [11:0]             code_fh;

    assign code_fh = {4'd0, code_reg} * {8'd0, fh};

    always_ff @(posedge aclk) begin
        if (cmd.calc_prod) begin
            row_fh_reg <= {4'd0, row_reg} * {8'd0, fh};
            col_fw_reg <= {4'd0, col_reg} * {8'd0, fw};
            gbase_reg  <= code_fh[GPR_STORE_AW-1:0];
        end
        if (cmd.calc_scaled) begin
            row_term_reg <= {16'd0, row_fh_reg} * {12'd0, line_pitch_reg};
            col_term_reg <= {3'd0, col_fw_reg} * {12'd0, bpp_reg};
        end
    end

    // pixel walk counters and running addresses
    logic [2:0]  px_reg;
    logic [2:0]  py_reg;
    logic [31:0] line_addr_reg;
    logic [31:0] pix_addr_reg;
    logic [31:0] origin;
    logic [31:0] next_line;

    assign origin    = frame_base_reg + {4'd0, row_term_reg} + {17'd0, col_term_reg};
    assign next_line = line_addr_reg + {16'd0, line_pitch_reg};

    assign status.row_end  = ({1'b0, px_reg} == (fw - 4'd1));
    assign status.cell_end = status.row_end && ({1'b0, py_reg} == (fh - 4'd1));

    always_ff @(posedge aclk) begin
        if (cmd.calc_origin) begin
            px_reg        <= 3'd0;
            py_reg        <= 3'd0;
            line_addr_reg <= origin;
            pix_addr_reg  <= origin;
        end else if (cmd.emit_pixel) begin
            if (status.row_end) begin
                px_reg        <= 3'd0;
                py_reg        <= py_reg + 3'd1;
                line_addr_reg <= next_line;
                pix_addr_reg  <= next_line;
            end else begin
                px_reg       <= px_reg + 3'd1;
                pix_addr_reg <= pix_addr_reg + {29'd0, bpp_reg};
            end
        end
    end

    // font store, one write and one registered read port
    logic [7:0]              glyph_mem [0:GPR_STORE_DEPTH-1];
    logic [7:0]              glyph_row_reg;
    logic [GPR_STORE_AW-1:0] row_index;

    assign row_index = gbase_reg + {{(GPR_STORE_AW-3){1'b0}}, py_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load_write) begin
            glyph_mem[in_faddr] <= in_fbyte;
        end
        if (cmd.fetch_row) begin
            glyph_row_reg <= glyph_mem[row_index];
        end
    end

    // output register
    logic        m_tvalid_reg;
    logic [31:0] out_addr_reg;
    logic [31:0] out_value_reg;
    logic        out_last_reg;
    logic        bit_set;

    assign bit_set = |(glyph_row_reg & (GPR_LEFT_BIT >> px_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit_pixel) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_pixel) begin
            out_addr_reg  <= pix_addr_reg;
            out_value_reg <= bit_set ? fg_reg : bg_reg;
            out_last_reg  <= status.cell_end;
        end
    end

    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign status.draw_item = (s_tuser == GPR_KIND_DRAW);
    assign status.size_zero = (fw == 4'd0) || (fh == 4'd0);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_value_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/glyph_to_pixel_renderer_top.sv -----
// top level of the glyph to pixel renderer: controller and datapath
// a load is written to the font store as it is accepted; a draw holds the input until its
// last pixel is loaded: accept, cell products, pitch and pixel size products, origin,
// then per glyph row one font store read and one pixel per cycle while the output is free
// the first pixel is valid after the first glyph row read; zero-size draws are dropped
// synchronous reset restores config defaults and empties the output, not the font store
module glyph_to_pixel_renderer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [gpr_pkg::GPR_CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpr_pkg::GPR_CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cell_column, cell_row, char_code, fg_color, bg_color, font_address, font_byte
    input  logic [gpr_pkg::GPR_S_TDATA_W-1:0]  s_tdata,
    // command
    input  logic                               s_tuser,
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pixel_address, pixel_value
    output logic [gpr_pkg::GPR_M_TDATA_W-1:0]  m_tdata,
    output logic                               m_tlast
);
    import gpr_pkg::*;

    gpr_cmd_t    cmd;
    gpr_status_t status;

    // sequencer
    gpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // font store, address arithmetic and output register
    gpr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
